// File: hdl/gf128_pkg.sv
// Shared widths and carry-less arithmetic helpers for the GF(2^128) multiplier.
`default_nettype none

package gf128_pkg;

    localparam int unsigned WORD_W     = 64;
    localparam int unsigned ELEM_W     = 2 * WORD_W;
    localparam int unsigned PROD_W     = 2 * ELEM_W - 1;
    localparam int unsigned SLICE_W    = 32;
    localparam int unsigned NUM_SLICES = ELEM_W / SLICE_W;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [ELEM_W-1:0] elem_t;
    typedef logic [PROD_W-1:0] prod_t;
    typedef logic [SLICE_W-1:0] slice_t;

    function automatic elem_t rev128(input elem_t v);
        elem_t r;
        for (int i = 0; i < ELEM_W; i++)
        begin
            r[i] = v[ELEM_W-1-i];
        end
        return r;
    endfunction

    // Partial carry-less product of a with one slice of b, placed at the slice offset.
    function automatic prod_t clmul_slice(input elem_t a, input slice_t bits,
                                          input int unsigned base);
        prod_t r;
        prod_t a_ext;
        r     = '0;
        a_ext = {{(PROD_W-ELEM_W){1'b0}}, a};
        for (int j = 0; j < SLICE_W; j++)
        begin
            if (bits[j])
            begin
                r = r ^ (a_ext << (base + j));
            end
        end
        return r;
    endfunction

    // Fold x^128 = x^7 + x^2 + x + 1 twice.
    function automatic elem_t gf_reduce(input prod_t c);
        logic [126:0] hi;
        logic [133:0] t;
        logic [5:0]   top;
        logic [12:0]  u;
        hi  = c[254:128];
        t   = {7'b0, hi} ^ {6'b0, hi, 1'b0} ^ {5'b0, hi, 2'b0} ^ {hi, 7'b0};
        top = t[133:128];
        u   = {7'b0, top} ^ {6'b0, top, 1'b0} ^ {5'b0, top, 2'b0} ^ {top, 7'b0};
        return c[127:0] ^ t[127:0] ^ {115'b0, u};
    endfunction

endpackage

`default_nettype wire

// File: hdl/gf128_if.sv
// Operand and product channel interfaces of the GF(2^128) multiplier.
`default_nettype none

interface gf128_op_if;
    import gf128_pkg::*;
    logic  valid;
    logic  ready;
    word_t a_low;
    word_t a_high;
    word_t b_low;
    word_t b_high;

    modport source (output valid, output a_low, output a_high, output b_low,
                    output b_high, input ready);
    modport sink   (input valid, input a_low, input a_high, input b_low,
                    input b_high, output ready);
endinterface

interface gf128_prod_if;
    import gf128_pkg::*;
    logic  valid;
    logic  ready;
    word_t product_low;
    word_t product_high;

    modport source (output valid, output product_low, output product_high, input ready);
    modport sink   (input valid, input product_low, input product_high, output ready);
endinterface

`default_nettype wire

// File: hdl/gf128_multiplier.sv
// Pipelined GF(2^128) multiplier: four carry-less slice stages and a reduction stage.
// Throughput: one request per cycle unless the product sink stalls; any stage advances when the next has room.
// Reset: all stage valid bits clear, bit_order resets to 1 (GCM bit-reflected).
// Bit order is sampled per request at accept and travels with it.
`default_nettype none

module gf128_multiplier (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_we,
    input  wire logic      cfg_wdata,
    gf128_op_if.sink       operands,
    gf128_prod_if.source   product
);
    import gf128_pkg::*;

    logic  bit_order_reg;

    logic  stg_v_reg   [NUM_SLICES];
    logic  stg_rev_reg [NUM_SLICES];
    elem_t stg_a_reg   [NUM_SLICES];
    elem_t stg_b_reg   [NUM_SLICES];
    prod_t stg_acc_reg [NUM_SLICES];

    logic  in_v   [NUM_SLICES];
    logic  in_rev [NUM_SLICES];
    elem_t in_a   [NUM_SLICES];
    elem_t in_b   [NUM_SLICES];
    prod_t in_acc [NUM_SLICES];
    logic  stg_rdy [NUM_SLICES];

    logic  out_v_reg;
    elem_t out_prod_reg;
    elem_t out_prod_next;
    logic  out_rdy;

    elem_t op_a;
    elem_t op_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_order_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            bit_order_reg <= cfg_wdata;
        end
    end

    assign op_a = {operands.a_high, operands.a_low};
    assign op_b = {operands.b_high, operands.b_low};

    assign out_rdy        = !out_v_reg || product.ready;
    assign operands.ready = stg_rdy[0];

    genvar s;
    generate
        for (s = 0; s < NUM_SLICES; s++)
        begin : g_stage
            if (s == 0)
            begin : g_first
                always_comb
                begin
                    in_v[s]   = operands.valid;
                    in_rev[s] = bit_order_reg;
                    in_a[s]   = bit_order_reg ? rev128(op_a) : op_a;
                    in_b[s]   = bit_order_reg ? rev128(op_b) : op_b;
                    in_acc[s] = '0;
                end
            end
            else
            begin : g_next
                always_comb
                begin
                    in_v[s]   = stg_v_reg[s-1];
                    in_rev[s] = stg_rev_reg[s-1];
                    in_a[s]   = stg_a_reg[s-1];
                    in_b[s]   = stg_b_reg[s-1];
                    in_acc[s] = stg_acc_reg[s-1];
                end
            end

            if (s == NUM_SLICES - 1)
            begin : g_last_rdy
                assign stg_rdy[s] = !stg_v_reg[s] || out_rdy;
            end
            else
            begin : g_mid_rdy
                assign stg_rdy[s] = !stg_v_reg[s] || stg_rdy[s+1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    stg_v_reg[s] <= 1'b0;
                end
                else if (stg_rdy[s])
                begin
                    stg_v_reg[s] <= in_v[s];
                end
            end

            always_ff @(posedge clk)
            begin
                if (stg_rdy[s] && in_v[s])
                begin
                    stg_rev_reg[s] <= in_rev[s];
                    stg_a_reg[s]   <= in_a[s];
                    stg_b_reg[s]   <= in_b[s];
                    stg_acc_reg[s] <= in_acc[s] ^ clmul_slice(
                        in_a[s], in_b[s][s*SLICE_W +: SLICE_W], s * SLICE_W);
                end
            end
        end
    endgenerate

    always_comb
    begin
        out_prod_next = gf_reduce(stg_acc_reg[NUM_SLICES-1]);
        if (stg_rev_reg[NUM_SLICES-1])
        begin
            out_prod_next = rev128(out_prod_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (out_rdy)
        begin
            out_v_reg <= stg_v_reg[NUM_SLICES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_rdy && stg_v_reg[NUM_SLICES-1])
        begin
            out_prod_reg <= out_prod_next;
        end
    end

    assign product.valid        = out_v_reg;
    assign product.product_low  = out_prod_reg[WORD_W-1:0];
    assign product.product_high = out_prod_reg[ELEM_W-1:WORD_W];

endmodule

`default_nettype wire
